// File: src/tks_pkg.sv
// Shared types, codes and sizes of the top-k score selector.
package tks_pkg;

	localparam int unsigned ID_W        = 16;
	localparam int unsigned SCORE_W     = 15;
	localparam int unsigned IN_SCORE_W  = 16;
	localparam int unsigned KEEP_DEF    = 16;
	localparam int unsigned MAX_OUT     = 16;

	localparam logic [1:0] ACT_CLEAR = 2'd0;
	localparam logic [1:0] ACT_OFFER = 2'd1;
	localparam logic [1:0] ACT_EMIT  = 2'd2;

	// one input item
	typedef struct packed {
		logic [1:0]                    action;
		logic [ID_W-1:0]               item_id;
		logic signed [IN_SCORE_W-1:0]  score;
	} tks_in_t;

	// one result item
	typedef struct packed {
		logic               found;
		logic [ID_W-1:0]    out_id;
		logic [SCORE_W-1:0] out_score;
		logic               last;
	} tks_out_t;

	// one table slot
	typedef struct packed {
		logic [ID_W-1:0]    id;
		logic [SCORE_W-1:0] score;
	} tks_slot_t;

	// scan modes of the shared compare unit
	typedef enum logic {
		MODE_MIN = 1'b0,
		MODE_MAX = 1'b1
	} tks_mode_t;

	// control of the compare unit from the sequencer
	typedef struct packed {
		logic      clr;
		logic      take;
		tks_mode_t mode;
	} tks_trk_ctrl_t;

endpackage

// File: src/tks_ram.sv
// Generic single-write, single-read RAM with registered read data.
module tks_ram #(
	parameter int unsigned WIDTH = 31,
	parameter int unsigned DEPTH = 16,
	localparam int unsigned AW = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
	input  logic             clk,
	input  logic             we,
	input  logic [AW-1:0]    waddr,
	input  logic [WIDTH-1:0] wdata,
	input  logic [AW-1:0]    raddr,
	output logic [WIDTH-1:0] rdata
);

	logic [WIDTH-1:0] mem_q [DEPTH];

	// write one entry, register the read
	always_ff @(posedge clk) begin
		if (we) begin
			mem_q[waddr] <= wdata;
		end
		rdata <= mem_q[raddr];
	end

endmodule

// File: src/tks_track.sv
// Shared compare unit: tracks the minimum or the next-best slot over a table scan.
module tks_track #(
	parameter int unsigned DEPTH = tks_pkg::KEEP_DEF,
	localparam int unsigned IW = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
	input  logic                           clk,
	input  logic                           arst_n,
	input  tks_pkg::tks_trk_ctrl_t         ctrl,
	input  logic [IW-1:0]                  slot,
	input  tks_pkg::tks_slot_t             entry,
	input  logic                           prev_valid,
	input  logic [tks_pkg::SCORE_W-1:0]    prev_score,
	input  logic [IW-1:0]                  prev_slot,
	output tks_pkg::tks_slot_t             best,
	output logic [IW-1:0]                  best_slot
);

	import tks_pkg::*;

	logic      has_q;
	tks_slot_t best_q;
	logic [IW-1:0] slot_q;
	logic      eligible;
	logic      upd;

	// decide whether the entry on the bus replaces the held one
	always_comb begin
		eligible = !prev_valid || (entry.score < prev_score) ||
			((entry.score == prev_score) && (slot > prev_slot));
		unique case (ctrl.mode)
			MODE_MIN: upd = !has_q || (entry.score < best_q.score);
			MODE_MAX: upd = eligible && (!has_q || (entry.score > best_q.score));
			default:  upd = 1'b0;
		endcase
	end

	// hold flag: a candidate has been seen in this pass
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			has_q <= 1'b0;
		end else if (ctrl.clr) begin
			has_q <= 1'b0;
		end else if (ctrl.take && upd) begin
			has_q <= 1'b1;
		end
	end

	// hold the candidate payload
	always_ff @(posedge clk) begin
		if (!ctrl.clr && ctrl.take && upd) begin
			best_q <= entry;
			slot_q <= slot;
		end
	end

	assign best      = best_q;
	assign best_slot = slot_q;

endmodule

// File: src/top_k_score_selector_top.sv
// Top level of the top-k score selector: sequencer, slot table and compare unit.
//
// Keeps the KEEP_COUNT best scored items offered. An item is taken when start
// is high and busy is low. A clear, an offer with a score of zero or below, and
// an offer while the table still has a free slot leave busy low. An offer to a
// full table walks all slots through the single compare unit to find the first
// lowest score: busy stays high while each slot is read in ST_SCAN and its
// registered read data taken, and while ST_DECIDE makes the write decision. An
// emit with n kept items runs min(n, 16) passes over the table and puts out one
// result per pass in descending score order (equal scores by slot); an emit on
// an empty table gives one result with found low in the cycle after it is
// taken. Each result is shown for one cycle under strobe and must be taken
// then: the receiver cannot hold results off.
module top_k_score_selector_top #(
	parameter int unsigned KEEP_COUNT = tks_pkg::KEEP_DEF
) (
	input  logic              clk,
	input  logic              arst_n,
	input  logic              start,
	output logic              busy,
	input  tks_pkg::tks_in_t  item,
	output logic              strobe,
	output tks_pkg::tks_out_t result
);

	import tks_pkg::*;

	localparam int unsigned IW = (KEEP_COUNT > 1) ? $clog2(KEEP_COUNT) : 1;
	localparam int unsigned CW = $clog2(KEEP_COUNT + 1);
	localparam int unsigned LW = $clog2(MAX_OUT + 1);
	localparam int unsigned SLOT_W = ID_W + SCORE_W;

	typedef enum logic [3:0] {
		ST_IDLE   = 4'b0001,
		ST_SCAN   = 4'b0010,
		ST_DECIDE = 4'b0100,
		ST_EOUT   = 4'b1000
	} tks_state_t;

	tks_state_t     state_q;
	logic [CW-1:0]  count_q;
	logic [CW-1:0]  cnt_q;
	logic [CW-1:0]  len_q;
	tks_mode_t      mode_q;
	logic           valid_s1;
	logic [IW-1:0]  idx_s1;
	logic [LW-1:0]  emitted_q;
	logic [LW-1:0]  lim_q;
	logic           prev_valid_q;
	logic [SCORE_W-1:0] prev_score_q;
	logic [IW-1:0]  prev_slot_q;
	logic [ID_W-1:0]    offer_id_q;
	logic [SCORE_W-1:0] offer_score_q;
	logic           strobe_q;
	tks_out_t       result_q;

	logic           accept;
	logic           score_ok;
	logic           full;
	logic           scan_done;
	logic           last_out;
	logic           ram_we;
	logic [IW-1:0]  ram_waddr;
	tks_slot_t      ram_wdata;
	logic [SLOT_W-1:0] ram_rdata;
	tks_slot_t      rd_entry;
	tks_trk_ctrl_t  trk_ctrl;
	tks_slot_t      best;
	logic [IW-1:0]  best_slot;

	assign busy      = (state_q != ST_IDLE);
	assign accept    = start && !busy;
	assign score_ok  = !item.score[IN_SCORE_W-1] && (item.score != '0);
	assign full      = (count_q == CW'(KEEP_COUNT));
	assign scan_done = (cnt_q == len_q);
	assign last_out  = ((emitted_q + LW'(1)) == lim_q);
	assign rd_entry  = tks_slot_t'(ram_rdata);

	// pick the table write: fill a free slot, or replace the lowest slot if the offer beats it
	always_comb begin
		ram_we    = 1'b0;
		ram_waddr = count_q[IW-1:0];
		ram_wdata = '{id: item.item_id, score: item.score[SCORE_W-1:0]};
		if (accept && (item.action == ACT_OFFER) && score_ok && !full) begin
			ram_we = 1'b1;
		end else if ((state_q == ST_DECIDE) && (offer_score_q > best.score)) begin
			ram_we    = 1'b1;
			ram_waddr = best_slot;
			ram_wdata = '{id: offer_id_q, score: offer_score_q};
		end
	end

	// drive the compare unit: clear on entry to a pass, take each read
	always_comb begin
		trk_ctrl.mode = mode_q;
		trk_ctrl.take = (state_q == ST_SCAN) && valid_s1;
		trk_ctrl.clr  = 1'b0;
		if (accept && (item.action == ACT_OFFER) && score_ok && full) begin
			trk_ctrl.clr = 1'b1;
		end else if (accept && (item.action == ACT_EMIT) && (count_q != '0)) begin
			trk_ctrl.clr = 1'b1;
		end else if ((state_q == ST_EOUT) && !last_out) begin
			trk_ctrl.clr = 1'b1;
		end
	end

	// sequencer and control state
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q      <= ST_IDLE;
			count_q      <= '0;
			cnt_q        <= '0;
			len_q        <= '0;
			mode_q       <= MODE_MIN;
			valid_s1     <= 1'b0;
			emitted_q    <= '0;
			lim_q        <= '0;
			prev_valid_q <= 1'b0;
			strobe_q     <= 1'b0;
		end else begin
			// raise the strobe after an output step or an empty-table emit
			strobe_q <= (state_q == ST_EOUT) ||
				(accept && (item.action == ACT_EMIT) && (count_q == '0));
			valid_s1 <= (state_q == ST_SCAN) && !scan_done;
			unique case (state_q)
				ST_IDLE: begin
					if (accept) begin
						case (item.action)
							ACT_CLEAR: count_q <= '0;
							ACT_OFFER: begin
								if (score_ok && !full) begin
									count_q <= count_q + CW'(1);
								end else if (score_ok) begin
									mode_q  <= MODE_MIN;
									len_q   <= CW'(KEEP_COUNT);
									cnt_q   <= '0;
									state_q <= ST_SCAN;
								end
							end
							ACT_EMIT: begin
								if (count_q != '0) begin
									mode_q       <= MODE_MAX;
									len_q        <= count_q;
									cnt_q        <= '0;
									emitted_q    <= '0;
									prev_valid_q <= 1'b0;
									if (int'(count_q) > MAX_OUT) begin
										lim_q <= LW'(MAX_OUT);
									end else begin
										lim_q <= LW'(count_q);
									end
									state_q <= ST_SCAN;
								end
							end
							default: ;
						endcase
					end
				end
				ST_SCAN: begin
					if (scan_done) begin
						state_q <= (mode_q == MODE_MIN) ? ST_DECIDE : ST_EOUT;
					end else begin
						cnt_q <= cnt_q + CW'(1);
					end
				end
				ST_DECIDE: begin
					state_q <= ST_IDLE;
				end
				ST_EOUT: begin
					prev_valid_q <= 1'b1;
					emitted_q    <= emitted_q + LW'(1);
					cnt_q        <= '0;
					state_q      <= last_out ? ST_IDLE : ST_SCAN;
				end
				default: state_q <= ST_IDLE;
			endcase
		end
	end

	// payload registers: offer under test, previous result, read slot, result
	always_ff @(posedge clk) begin
		idx_s1 <= cnt_q[IW-1:0];
		if (accept) begin
			offer_id_q    <= item.item_id;
			offer_score_q <= item.score[SCORE_W-1:0];
		end
		if (accept && (item.action == ACT_EMIT) && (count_q == '0)) begin
			result_q <= '{found: 1'b0, out_id: '0, out_score: '0, last: 1'b1};
		end else if (state_q == ST_EOUT) begin
			result_q <= '{found: 1'b1, out_id: best.id, out_score: best.score,
				last: last_out};
			prev_score_q <= best.score;
			prev_slot_q  <= best_slot;
		end
	end

	tks_ram #(
		.WIDTH(SLOT_W),
		.DEPTH(KEEP_COUNT)
	) u_ram (
		.clk   (clk),
		.we    (ram_we),
		.waddr (ram_waddr),
		.wdata (SLOT_W'(ram_wdata)),
		.raddr (cnt_q[IW-1:0]),
		.rdata (ram_rdata)
	);

	tks_track #(
		.DEPTH(KEEP_COUNT)
	) u_track (
		.clk        (clk),
		.arst_n     (arst_n),
		.ctrl       (trk_ctrl),
		.slot       (idx_s1),
		.entry      (rd_entry),
		.prev_valid (prev_valid_q),
		.prev_score (prev_score_q),
		.prev_slot  (prev_slot_q),
		.best       (best),
		.best_slot  (best_slot)
	);

	assign strobe = strobe_q;
	assign result = result_q;

	// the fill count never passes the table size
	a_count_bound: assert property (@(posedge clk) disable iff (!arst_n)
		int'(count_q) <= KEEP_COUNT)
		else $error("fill count beyond table size");

	// an empty-table result always closes the run
	a_empty_last: assert property (@(posedge clk) disable iff (!arst_n)
		strobe && !result.found |-> result.last)
		else $error("empty result without last");

	// the table is written only on a fill or at the replace decision
	a_write_src: assert property (@(posedge clk) disable iff (!arst_n)
		ram_we |-> (state_q == ST_IDLE) || (state_q == ST_DECIDE))
		else $error("table write outside fill or replace");

	// a result follows an output step or an empty emit
	a_strobe_src: assert property (@(posedge clk) disable iff (!arst_n)
		strobe |-> $past(state_q == ST_EOUT) || $past(accept))
		else $error("result strobe without cause");

endmodule
